FILE: hdl/ffsa_pkg.sv
package ffsa_pkg;
  localparam int unsigned MaxSegments = 64;
  localparam int unsigned MaxRegions  = 16;
  localparam int unsigned PageBytes   = 4096;
  localparam int unsigned SegIdxW     = $clog2(MaxSegments);
  localparam int unsigned SegCntW     = $clog2(MaxSegments + 1);
  localparam int unsigned RegIdxW     = $clog2(MaxRegions);
  localparam int unsigned RegCntW     = $clog2(MaxRegions + 1);
  localparam int unsigned PageW       = $clog2(PageBytes);
  localparam int unsigned LenW        = 21;
  localparam int unsigned AddrW       = 32;
  localparam logic [AddrW-1:0] VirtBaseStart = 32'd1000;

  typedef enum logic [1:0] {
    CmdAlloc     = 2'd0,
    CmdFree      = 2'd1,
    CmdTranslate = 2'd2,
    CmdBad       = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StZeroSize = 2'd1,
    StNoRoom   = 2'd2,
    StBadAddr  = 2'd3
  } status_e;

  // One segment table entry
  typedef struct packed {
    logic [AddrW-1:0]   start;
    logic [LenW-1:0]    length;
    logic               used;
    logic [RegIdxW-1:0] region;
  } seg_t;
endpackage

FILE: hdl/ffsa_seg_ram.sv
module ffsa_seg_ram (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [ffsa_pkg::SegIdxW-1:0] waddr_i,
  input  ffsa_pkg::seg_t          wdata_i,
  input  logic [ffsa_pkg::SegIdxW-1:0] raddr_i,
  output ffsa_pkg::seg_t          rdata_o
);
  import ffsa_pkg::*;

  seg_t mem_q [MaxSegments];

  // Write one entry, read one entry registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: hdl/first_fit_segment_allocator_top.sv
// First-fit segment allocator.
// Requests arrive on the s_axis channel: tdata carries cmd, req_size and address,
// s_axis_tready is high only while the block is idle. Each request produces
// exactly one response on the m_axis channel (status, virt_addr, region_index,
// region_offset). The segment table sits in a single-port-write, one-read RAM and
// is scanned one entry at a time by a small sequencer (a read state, then a check state);
// inserting a split hole or removing a merged entry moves the table entry by entry.
// One request at a time: the next is taken once the response register is free.
// Reset clears the segment and region counts and sets the next virtual base
// to 1000; the tables need no clearing pass. When the receiver stalls, the
// response holds in its register and no new request is taken.
module first_fit_segment_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,  // cmd[1:0], req_size[22:2], address[54:23], 0
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o   // status[1:0], virt_addr[33:2],
                                       // region_index[37:34], region_offset[58:38], 0
);
  import ffsa_pkg::*;

  typedef enum logic [3:0] {
    SIdle, SScanRd, SScanChk, SShiftRd, SShiftWr, SSplit,
    SFreeChk, SPrevRd, SPrevChk, SNextRd, SNextChk, SRemRd, SRemWr, SRegion, SDone
  } state_e;

  state_e state_q;
  logic [1:0]          cmd_q;
  logic [LenW-1:0]     size_q;
  logic [AddrW-1:0]    addr_q;
  logic [SegCntW-1:0]  seg_count_q;
  logic [RegCntW-1:0]  region_count_q;
  logic [AddrW-1:0]    next_base_q;
  logic [SegCntW-1:0]  idx_q;   // scan index / found entry
  logic [SegCntW-1:0]  k_q;     // move pointer
  seg_t                hit_q;   // found entry copy
  seg_t                cur_q;   // merged entry being built
  logic                wb_q;    // write cur_q back at idx_q when done
  logic [1:0]          status_q;
  logic [AddrW-1:0]    va_q;
  logic [RegIdxW-1:0]  ridx_q;
  logic [LenW-1:0]     roff_q;
  logic                out_v_q;

  logic [AddrW-1:0] region_base_q [MaxRegions];

  logic                we;
  logic [SegIdxW-1:0]  waddr, raddr;
  seg_t                wdata, rdata;

  ffsa_seg_ram u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Shared combinational datapath: hit test on the entry just read, plus size rounding and room checks
  logic [AddrW:0]   seg_end;
  logic             in_seg;
  logic [LenW:0]    logical;
  logic [AddrW:0]   end_va;
  logic             need_two;
  logic [SegCntW:0] need_cnt;
  logic             region_ok;

  assign seg_end  = {1'b0, rdata.start} + {{(AddrW-LenW+1){1'b0}}, rdata.length};
  assign in_seg   = ({1'b0, addr_q} >= {1'b0, rdata.start}) && ({1'b0, addr_q} < seg_end);
  assign logical  = ({1'b0, size_q} + (LenW+1)'(PageBytes - 1))
                    & ~(LenW+1)'(PageBytes - 1);
  assign end_va   = {1'b0, next_base_q} + {{(AddrW-LenW){1'b0}}, logical};
  assign need_two = logical[LenW-1:0] != size_q;
  assign need_cnt = {1'b0, seg_count_q} + (need_two ? (SegCntW+1)'(2) : (SegCntW+1)'(1));

  // New region fits in length, address space and both tables
  assign region_ok = !(logical > (LenW+1)'({LenW{1'b1}}) || end_va[AddrW] ||
                       region_count_q == RegCntW'(MaxRegions) ||
                       need_cnt > (SegCntW+1)'(MaxSegments));

  assign s_axis_tready_o = (state_q == SIdle) && !out_v_q;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {5'd0, roff_q, ridx_q, va_q, status_q};

  // RAM port control
  always_comb begin
    we    = 1'b0;
    waddr = idx_q[SegIdxW-1:0];
    wdata = cur_q;
    raddr = idx_q[SegIdxW-1:0];
    unique case (state_q)
      SShiftRd: raddr = SegIdxW'(k_q - 1'b1);
      SShiftWr: begin we = 1'b1; waddr = k_q[SegIdxW-1:0]; wdata = rdata; end
      SSplit:   begin we = 1'b1; wdata = cur_q; end
      SPrevRd:  raddr = SegIdxW'(idx_q - 1'b1);
      SNextRd:  raddr = SegIdxW'(idx_q + 1'b1);
      SRemRd:   raddr = SegIdxW'(k_q + 1'b1);
      SRemWr:   begin we = 1'b1; waddr = k_q[SegIdxW-1:0]; wdata = rdata; end
      SRegion:  begin
        we    = region_ok;
        waddr = seg_count_q[SegIdxW-1:0];
        wdata = '{start: next_base_q, length: size_q, used: 1'b1,
                  region: region_count_q[RegIdxW-1:0]};
      end
      SDone:    begin we = wb_q; wdata = cur_q; end
      default:  ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= SIdle;
      seg_count_q    <= '0;
      region_count_q <= '0;
      next_base_q    <= VirtBaseStart;
      out_v_q        <= 1'b0;
    end else begin
      if (out_v_q && m_axis_tready_i) out_v_q <= 1'b0;
      unique case (state_q)
        SIdle: begin
          if (s_axis_tvalid_i && !out_v_q) begin
            cmd_q    <= s_axis_tdata_i[1:0];
            size_q   <= s_axis_tdata_i[22:2];
            addr_q   <= s_axis_tdata_i[54:23];
            idx_q    <= '0;
            wb_q     <= 1'b0;
            va_q     <= '0;
            ridx_q   <= '0;
            roff_q   <= '0;
            if (s_axis_tdata_i[1:0] == CmdBad) begin
              status_q <= StBadAddr;
              state_q  <= SDone;
            end else if (s_axis_tdata_i[1:0] == CmdAlloc && s_axis_tdata_i[22:2] == '0) begin
              status_q <= StZeroSize;
              state_q  <= SDone;
            end else if (seg_count_q == '0) begin
              status_q <= StBadAddr;
              state_q  <= (s_axis_tdata_i[1:0] == CmdAlloc) ? SRegion : SDone;
            end else begin
              status_q <= StBadAddr;
              state_q  <= SScanRd;
            end
          end
        end
        SScanRd: state_q <= SScanChk;
        SScanChk: begin
          hit_q <= rdata;
          if (cmd_q == CmdAlloc) begin
            if (!rdata.used && rdata.length >= size_q) begin
              if (rdata.length != size_q && seg_count_q == SegCntW'(MaxSegments)) begin
                status_q <= StNoRoom;
                state_q  <= SDone;
              end else begin
                status_q <= StOk;
                va_q     <= rdata.start;
                cur_q    <= '{start: rdata.start, length: size_q, used: 1'b1,
                              region: rdata.region};
                wb_q     <= 1'b1;
                k_q      <= seg_count_q;
                state_q  <= (rdata.length != size_q) ? SShiftRd : SDone;
              end
            end else if (idx_q + 1'b1 == seg_count_q) state_q <= SRegion;
            else begin idx_q <= idx_q + 1'b1; state_q <= SScanRd; end
          end else if (in_seg) begin
            cur_q <= rdata;
            if (cmd_q == CmdTranslate) begin
              if (rdata.used && {1'b0, rdata.region} < region_count_q) begin
                status_q <= StOk;
                ridx_q   <= rdata.region;
                roff_q   <= LenW'(addr_q - region_base_q[rdata.region]);
              end
              state_q <= SDone;
            end else state_q <= SFreeChk;
          end else if (idx_q + 1'b1 == seg_count_q) state_q <= SDone;
          else begin idx_q <= idx_q + 1'b1; state_q <= SScanRd; end
        end
        // Open a gap after the hit for the split hole
        SShiftRd: state_q <= (k_q > idx_q + 1'b1) ? SShiftWr : SSplit;
        SShiftWr: begin k_q <= k_q - 1'b1; state_q <= SShiftRd; end
        SSplit: begin
          // write used part at idx, then hole at idx+1
          cur_q        <= '{start: hit_q.start + AddrW'(size_q),
                            length: hit_q.length - size_q, used: 1'b0,
                            region: cur_q.region};
          idx_q        <= idx_q + 1'b1;
          seg_count_q  <= seg_count_q + 1'b1;
          state_q      <= SDone;
          status_q     <= StOk;
        end
        SFreeChk: begin
          if (!hit_q.used || hit_q.start != addr_q) state_q <= SDone;
          else begin
            status_q   <= StOk;
            cur_q.used <= 1'b0;
            wb_q       <= 1'b1;
            if (idx_q != '0) state_q <= SPrevRd;
            else if (idx_q + 1'b1 >= seg_count_q) state_q <= SDone;
            else state_q <= SNextRd;
          end
        end
        SPrevRd: state_q <= SPrevChk;
        SPrevChk: begin
          if (!rdata.used && rdata.region == cur_q.region) begin
            // absorb the hit into the previous hole, remove the hit
            cur_q        <= '{start: rdata.start, length: rdata.length + cur_q.length,
                              used: cur_q.used, region: cur_q.region};
            idx_q        <= idx_q - 1'b1;
            k_q          <= idx_q;
            seg_count_q  <= seg_count_q - 1'b1;
            state_q      <= (idx_q + 1'b1 < seg_count_q) ? SRemRd : SNextRd;
          end else state_q <= (idx_q + 1'b1 < seg_count_q) ? SNextRd : SDone;
        end
        SNextRd: state_q <= (idx_q + 1'b1 < seg_count_q) ? SNextChk : SDone;
        SNextChk: begin
          if (!rdata.used && rdata.region == cur_q.region) begin
            cur_q.length <= cur_q.length + rdata.length;
            k_q          <= idx_q + 1'b1;
            seg_count_q  <= seg_count_q - 1'b1;
            state_q      <= (idx_q + 2'd2 < seg_count_q) ? SRemRd : SDone;
          end else state_q <= SDone;
        end
        // Close the gap left at k by moving later entries down
        SRemRd: state_q <= SRemWr;
        SRemWr: begin
          k_q <= k_q + 1'b1;
          if (k_q + 1'b1 < seg_count_q) state_q <= SRemRd;
          else state_q <= (cmd_q == CmdFree && cur_q.start != addr_q) ? SNextRd : SDone;
        end
        SRegion: begin
          if (!region_ok) begin
            status_q <= StNoRoom;
            state_q  <= SDone;
          end else begin
            // used entry goes in now, the trailing hole (if rounding leaves one) when done
            region_base_q[region_count_q[RegIdxW-1:0]] <= next_base_q;
            status_q <= StOk;
            va_q     <= next_base_q;
            cur_q    <= '{start: next_base_q + AddrW'(size_q),
                          length: logical[LenW-1:0] - size_q, used: 1'b0,
                          region: region_count_q[RegIdxW-1:0]};
            idx_q    <= seg_count_q + 1'b1;
            wb_q     <= need_two;
            seg_count_q    <= need_cnt[SegCntW-1:0];
            region_count_q <= region_count_q + 1'b1;
            next_base_q    <= end_va[AddrW-1:0];
            state_q  <= SDone;
          end
        end
        SDone: begin
          out_v_q <= 1'b1;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule
